// File: design/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared defaults and width helpers for the segment intersection block.
// ----------------------------------------------------------------------------
package sgi_pkg;

   // Default configuration of the block.
   localparam int COORD_BITS_DEF      = 16;
   localparam int PARAM_FRAC_BITS_DEF = 16;
   localparam int POINT_FRAC_BITS_DEF = 8;

   // Width of the magnitude of a cross product of two coordinate differences.
   function automatic int mag_bits(input int coord_bits);
      return 2 * coord_bits + 2;
   endfunction

endpackage

// File: design/sgi_cross.sv
// ----------------------------------------------------------------------------
// sgi_cross
// Front end: differences, cross products, sign normalisation and hit test.
// ----------------------------------------------------------------------------
module sgi_cross #(
   parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   input  logic signed [COORD_BITS-1:0]                   ax,
   input  logic signed [COORD_BITS-1:0]                   ay,
   input  logic signed [COORD_BITS-1:0]                   bx,
   input  logic signed [COORD_BITS-1:0]                   by_coord,
   input  logic signed [COORD_BITS-1:0]                   cx,
   input  logic signed [COORD_BITS-1:0]                   cy,
   input  logic signed [COORD_BITS-1:0]                   dx,
   input  logic signed [COORD_BITS-1:0]                   dy,
   output logic                                           out_valid,
   output logic                                           out_hit,
   output logic                                           t_full,
   output logic                                           u_full,
   output logic [sgi_pkg::mag_bits(COORD_BITS)-1:0]       den,
   output logic [sgi_pkg::mag_bits(COORD_BITS)-1:0]       num_t,
   output logic [sgi_pkg::mag_bits(COORD_BITS)-1:0]       num_u,
   output logic signed [COORD_BITS-1:0]                   a_x,
   output logic signed [COORD_BITS-1:0]                   a_y,
   output logic signed [COORD_BITS:0]                     r_x,
   output logic signed [COORD_BITS:0]                     r_y
);
   import sgi_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int PW = mag_bits(C);
   localparam int SW = PW + 1;

   // Valid pipeline through the six front stages.
   logic [5:0] vld_ff, vld_in;

   // Stage 0: input capture.
   logic signed [C-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff, dx_ff, dy_ff;
   // Stage 1: difference vectors.
   logic signed [C:0]   rx_ff, ry_ff, sx_ff, sy_ff, qx_ff, qy_ff;
   logic signed [C:0]   rx_in, ry_in, sx_in, sy_in, qx_in, qy_in;
   logic signed [C-1:0] ax1_ff, ay1_ff;
   // Stage 2: products.
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [C-1:0]  ax2_ff, ay2_ff, ax3_ff, ay3_ff, ax4_ff, ay4_ff, ax5_ff, ay5_ff;
   logic signed [C:0]    rx2_ff, ry2_ff, rx3_ff, ry3_ff, rx4_ff, ry4_ff, rx5_ff, ry5_ff;
   // Stage 3: cross products.
   logic signed [SW-1:0] den3_ff, nt3_ff, nu3_ff;
   logic signed [SW-1:0] den3_in, nt3_in, nu3_in;
   // Stage 4: sign normalised.
   logic signed [SW-1:0] den4_ff, nt4_ff, nu4_ff;
   logic signed [SW-1:0] den4_in, nt4_in, nu4_in;
   // Stage 5: test result.
   logic                 hit5_ff, tf5_ff, uf5_ff, hit5_in;
   logic [PW-1:0]        den5_ff, nt5_ff, nu5_ff;

   assign vld_in = {vld_ff[4:0], in_valid};

   // Control: valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Differences in one bit more than a coordinate so that they never wrap.
   assign rx_in = {bx_ff[C-1], bx_ff} - {ax_ff[C-1], ax_ff};
   assign ry_in = {by_ff[C-1], by_ff} - {ay_ff[C-1], ay_ff};
   assign sx_in = {dx_ff[C-1], dx_ff} - {cx_ff[C-1], cx_ff};
   assign sy_in = {dy_ff[C-1], dy_ff} - {cy_ff[C-1], cy_ff};
   assign qx_in = {cx_ff[C-1], cx_ff} - {ax_ff[C-1], ax_ff};
   assign qy_in = {cy_ff[C-1], cy_ff} - {ay_ff[C-1], ay_ff};

   // Cross products as exact differences of two products.
   assign den3_in = SW'(p0_ff) - SW'(p1_ff);
   assign nt3_in  = SW'(p2_ff) - SW'(p3_ff);
   assign nu3_in  = SW'(p4_ff) - SW'(p5_ff);

   // Negate all three terms when the denominator is negative.
   assign den4_in = den3_ff[SW-1] ? -den3_ff : den3_ff;
   assign nt4_in  = den3_ff[SW-1] ? -nt3_ff  : nt3_ff;
   assign nu4_in  = den3_ff[SW-1] ? -nu3_ff  : nu3_ff;

   // Both parameters must lie in the closed unit interval.
   assign hit5_in = (den4_ff != '0) && !nt4_ff[SW-1] && !nu4_ff[SW-1]
                    && (nt4_ff <= den4_ff) && (nu4_ff <= den4_ff);

   // Datapath registers.
   always_ff @(posedge clock) begin
      ax_ff  <= ax;       ay_ff  <= ay;
      bx_ff  <= bx;       by_ff  <= by_coord;
      cx_ff  <= cx;       cy_ff  <= cy;
      dx_ff  <= dx;       dy_ff  <= dy;
      rx_ff  <= rx_in;    ry_ff  <= ry_in;
      sx_ff  <= sx_in;    sy_ff  <= sy_in;
      qx_ff  <= qx_in;    qy_ff  <= qy_in;
      ax1_ff <= ax_ff;    ay1_ff <= ay_ff;
      p0_ff  <= PW'(rx_ff) * PW'(sy_ff);
      p1_ff  <= PW'(ry_ff) * PW'(sx_ff);
      p2_ff  <= PW'(qx_ff) * PW'(sy_ff);
      p3_ff  <= PW'(qy_ff) * PW'(sx_ff);
      p4_ff  <= PW'(qx_ff) * PW'(ry_ff);
      p5_ff  <= PW'(qy_ff) * PW'(rx_ff);
      ax2_ff <= ax1_ff;   ay2_ff <= ay1_ff;
      rx2_ff <= rx_ff;    ry2_ff <= ry_ff;
      den3_ff <= den3_in; nt3_ff <= nt3_in; nu3_ff <= nu3_in;
      ax3_ff <= ax2_ff;   ay3_ff <= ay2_ff;
      rx3_ff <= rx2_ff;   ry3_ff <= ry2_ff;
      den4_ff <= den4_in; nt4_ff <= nt4_in; nu4_ff <= nu4_in;
      ax4_ff <= ax3_ff;   ay4_ff <= ay3_ff;
      rx4_ff <= rx3_ff;   ry4_ff <= ry3_ff;
      hit5_ff <= hit5_in;
      tf5_ff  <= (nt4_ff == den4_ff);
      uf5_ff  <= (nu4_ff == den4_ff);
      den5_ff <= den4_ff[PW-1:0];
      nt5_ff  <= nt4_ff[PW-1:0];
      nu5_ff  <= nu4_ff[PW-1:0];
      ax5_ff <= ax4_ff;   ay5_ff <= ay4_ff;
      rx5_ff <= rx4_ff;   ry5_ff <= ry4_ff;
   end

   assign out_valid = vld_ff[5];
   assign out_hit   = hit5_ff;
   assign t_full    = tf5_ff;
   assign u_full    = uf5_ff;
   assign den       = den5_ff;
   assign num_t     = nt5_ff;
   assign num_u     = nu5_ff;
   assign a_x       = ax5_ff;
   assign a_y       = ay5_ff;
   assign r_x       = rx5_ff;
   assign r_y       = ry5_ff;

endmodule

// File: design/sgi_div_cell.sv
// ----------------------------------------------------------------------------
// sgi_div_cell
// One restoring division step for both parameters; hands its item on each cycle.
// ----------------------------------------------------------------------------
module sgi_div_cell #(
   parameter int COORD_BITS      = sgi_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC_BITS = sgi_pkg::PARAM_FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic                                     in_hit,
   input  logic                                     in_t_full,
   input  logic                                     in_u_full,
   input  logic [sgi_pkg::mag_bits(COORD_BITS)-1:0] in_den,
   input  logic [sgi_pkg::mag_bits(COORD_BITS)-1:0] in_rem_t,
   input  logic [sgi_pkg::mag_bits(COORD_BITS)-1:0] in_rem_u,
   input  logic [PARAM_FRAC_BITS-1:0]               in_q_t,
   input  logic [PARAM_FRAC_BITS-1:0]               in_q_u,
   input  logic signed [COORD_BITS-1:0]             in_a_x,
   input  logic signed [COORD_BITS-1:0]             in_a_y,
   input  logic signed [COORD_BITS:0]               in_r_x,
   input  logic signed [COORD_BITS:0]               in_r_y,
   output logic                                     out_valid,
   output logic                                     out_hit,
   output logic                                     out_t_full,
   output logic                                     out_u_full,
   output logic [sgi_pkg::mag_bits(COORD_BITS)-1:0] out_den,
   output logic [sgi_pkg::mag_bits(COORD_BITS)-1:0] out_rem_t,
   output logic [sgi_pkg::mag_bits(COORD_BITS)-1:0] out_rem_u,
   output logic [PARAM_FRAC_BITS-1:0]               out_q_t,
   output logic [PARAM_FRAC_BITS-1:0]               out_q_u,
   output logic signed [COORD_BITS-1:0]             out_a_x,
   output logic signed [COORD_BITS-1:0]             out_a_y,
   output logic signed [COORD_BITS:0]               out_r_x,
   output logic signed [COORD_BITS:0]               out_r_y
);
   import sgi_pkg::*;

   localparam int PW = mag_bits(COORD_BITS);
   localparam int F  = PARAM_FRAC_BITS;

   logic          vld_ff;
   logic          hit_ff, tf_ff, uf_ff;
   logic [PW-1:0] den_ff, rt_ff, ru_ff, rt_in, ru_in;
   logic [F-1:0]  qt_ff, qu_ff;
   logic signed [COORD_BITS-1:0] ax_ff, ay_ff;
   logic signed [COORD_BITS:0]   rx_ff, ry_ff;
   logic [PW:0]   sh_t, sh_u;
   logic          ge_t, ge_u;

   // Shift the remainder and subtract the denominator where it fits.
   assign sh_t  = {in_rem_t, 1'b0};
   assign sh_u  = {in_rem_u, 1'b0};
   assign ge_t  = sh_t >= {1'b0, in_den};
   assign ge_u  = sh_u >= {1'b0, in_den};
   assign rt_in = ge_t ? PW'(sh_t - {1'b0, in_den}) : sh_t[PW-1:0];
   assign ru_in = ge_u ? PW'(sh_u - {1'b0, in_den}) : sh_u[PW-1:0];

   // Control: the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_valid;
      end
   end

   // Payload moves on to the next cell every cycle.
   always_ff @(posedge clock) begin
      hit_ff <= in_hit;
      tf_ff  <= in_t_full;
      uf_ff  <= in_u_full;
      den_ff <= in_den;
      rt_ff  <= rt_in;
      ru_ff  <= ru_in;
      qt_ff  <= {in_q_t[F-2:0], ge_t};
      qu_ff  <= {in_q_u[F-2:0], ge_u};
      ax_ff  <= in_a_x;
      ay_ff  <= in_a_y;
      rx_ff  <= in_r_x;
      ry_ff  <= in_r_y;
   end

   assign out_valid  = vld_ff;
   assign out_hit    = hit_ff;
   assign out_t_full = tf_ff;
   assign out_u_full = uf_ff;
   assign out_den    = den_ff;
   assign out_rem_t  = rt_ff;
   assign out_rem_u  = ru_ff;
   assign out_q_t    = qt_ff;
   assign out_q_u    = qu_ff;
   assign out_a_x    = ax_ff;
   assign out_a_y    = ay_ff;
   assign out_r_x    = rx_ff;
   assign out_r_y    = ry_ff;

endmodule

// File: design/sgi_point.sv
// ----------------------------------------------------------------------------
// sgi_point
// Crossing point A + r*t in fixed point, floored, and the result register.
// ----------------------------------------------------------------------------
module sgi_point #(
   parameter int COORD_BITS      = sgi_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC_BITS = sgi_pkg::PARAM_FRAC_BITS_DEF,
   parameter int POINT_FRAC_BITS = sgi_pkg::POINT_FRAC_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   input  logic                                        in_hit,
   input  logic                                        in_t_full,
   input  logic                                        in_u_full,
   input  logic [PARAM_FRAC_BITS-1:0]                  in_q_t,
   input  logic [PARAM_FRAC_BITS-1:0]                  in_q_u,
   input  logic signed [COORD_BITS-1:0]                in_a_x,
   input  logic signed [COORD_BITS-1:0]                in_a_y,
   input  logic signed [COORD_BITS:0]                  in_r_x,
   input  logic signed [COORD_BITS:0]                  in_r_y,
   output logic                                        rsp_valid,
   output logic                                        rsp_hit,
   output logic signed [COORD_BITS+POINT_FRAC_BITS-1:0] rsp_point_x,
   output logic signed [COORD_BITS+POINT_FRAC_BITS-1:0] rsp_point_y,
   output logic [PARAM_FRAC_BITS:0]                    rsp_t_param,
   output logic [PARAM_FRAC_BITS:0]                    rsp_u_param
);
   import sgi_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int F  = PARAM_FRAC_BITS;
   localparam int P  = POINT_FRAC_BITS;
   localparam int OW = C + P;
   localparam int MW = C + F + 3;
   localparam int XW = MW + P + 1;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   logic          vld_ff, hit_ff;
   logic [F:0]    tq_in, uq_in, tq_ff, uq_ff;
   logic signed [MW-1:0] mx_ff, my_ff, vx, vy;
   logic signed [C-1:0]  ax_ff, ay_ff;
   logic signed [XW-1:0] ex, ey;
   logic signed [OW-1:0] px, py;
   logic          ov_ff, oh_ff;
   logic signed [OW-1:0] ox_ff, oy_ff;
   logic [F:0]    ot_ff, ou_ff;
   logic          oh_in;

   // A parameter equal to the denominator is exactly one.
   assign tq_in = in_t_full ? ONE : {1'b0, in_q_t};
   assign uq_in = in_u_full ? ONE : {1'b0, in_q_u};

   // Point A plus the offset along the first segment, scaled by the fraction bits of t.
   assign vx = (MW'(ax_ff) <<< F) + mx_ff;
   assign vy = (MW'(ay_ff) <<< F) + my_ff;
   assign ex = XW'(vx);
   assign ey = XW'(vy);

   // Rescale to the point format; the arithmetic shift floors.
   generate
      if (P >= F) begin : g_up
         assign px = OW'(ex <<< (P - F));
         assign py = OW'(ey <<< (P - F));
      end else begin : g_down
         assign px = OW'(ex >>> (F - P));
         assign py = OW'(ey >>> (F - P));
      end
   endgenerate

   assign oh_in = vld_ff & hit_ff;

   // Control and result registers; a miss gives all zero fields.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         ov_ff  <= 1'b0;
         oh_ff  <= 1'b0;
         ox_ff  <= '0;
         oy_ff  <= '0;
         ot_ff  <= '0;
         ou_ff  <= '0;
      end else begin
         vld_ff <= in_valid;
         ov_ff  <= vld_ff;
         oh_ff  <= oh_in;
         ox_ff  <= oh_in ? px : '0;
         oy_ff  <= oh_in ? py : '0;
         ot_ff  <= oh_in ? tq_ff : '0;
         ou_ff  <= oh_in ? uq_ff : '0;
      end
   end

   // Multiply stage payload.
   always_ff @(posedge clock) begin
      hit_ff <= in_hit;
      tq_ff  <= tq_in;
      uq_ff  <= uq_in;
      ax_ff  <= in_a_x;
      ay_ff  <= in_a_y;
      mx_ff  <= MW'(in_r_x) * MW'($signed({1'b0, tq_in}));
      my_ff  <= MW'(in_r_y) * MW'($signed({1'b0, tq_in}));
   end

   assign rsp_valid   = ov_ff;
   assign rsp_hit     = oh_ff;
   assign rsp_point_x = ox_ff;
   assign rsp_point_y = oy_ff;
   assign rsp_t_param = ot_ff;
   assign rsp_u_param = ou_ff;

endmodule

// File: design/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection
// Exact intersection test of two segments with fixed-point t, u and point.
//
//   channel  ports            transfer
//   request  start, req_*     start high while busy is low
//   result   rsp_valid, rsp_* one cycle with rsp_valid high, always taken
//
// A new pair is taken on every clock; busy stays low.
// Each result follows its request through six front stages, one division cell
// per fraction bit, then the multiply and output stages.
// Results leave in request order. Synchronous reset clears all valid bits.
// The receiver cannot stall, so no back-pressure exists inside the pipeline.
// ----------------------------------------------------------------------------
module segment_intersection #(
   parameter int COORD_BITS      = sgi_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC_BITS = sgi_pkg::PARAM_FRAC_BITS_DEF,
   parameter int POINT_FRAC_BITS = sgi_pkg::POINT_FRAC_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  logic signed [COORD_BITS-1:0]                 req_ax,
   input  logic signed [COORD_BITS-1:0]                 req_ay,
   input  logic signed [COORD_BITS-1:0]                 req_bx,
   input  logic signed [COORD_BITS-1:0]                 req_by_coord,
   input  logic signed [COORD_BITS-1:0]                 req_cx,
   input  logic signed [COORD_BITS-1:0]                 req_cy,
   input  logic signed [COORD_BITS-1:0]                 req_dx,
   input  logic signed [COORD_BITS-1:0]                 req_dy,
   output logic                                         rsp_valid,
   output logic                                         rsp_hit,
   output logic signed [COORD_BITS+POINT_FRAC_BITS-1:0] rsp_point_x,
   output logic signed [COORD_BITS+POINT_FRAC_BITS-1:0] rsp_point_y,
   output logic [PARAM_FRAC_BITS:0]                     rsp_t_param,
   output logic [PARAM_FRAC_BITS:0]                     rsp_u_param
);
   import sgi_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int F  = PARAM_FRAC_BITS;
   localparam int PW = mag_bits(C);
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   // Links between the cells of the division chain; index 0 is the front end.
   logic          c_vld [0:F];
   logic          c_hit [0:F];
   logic          c_tf  [0:F];
   logic          c_uf  [0:F];
   logic [PW-1:0] c_den [0:F];
   logic [PW-1:0] c_rt  [0:F];
   logic [PW-1:0] c_ru  [0:F];
   logic [F-1:0]  c_qt  [0:F];
   logic [F-1:0]  c_qu  [0:F];
   logic signed [C-1:0] c_ax [0:F];
   logic signed [C-1:0] c_ay [0:F];
   logic signed [C:0]   c_rx [0:F];
   logic signed [C:0]   c_ry [0:F];

   assign busy = 1'b0;

   // Front end: cross products and the hit test.
   sgi_cross #(.COORD_BITS(C)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .ax        (req_ax),
      .ay        (req_ay),
      .bx        (req_bx),
      .by_coord  (req_by_coord),
      .cx        (req_cx),
      .cy        (req_cy),
      .dx        (req_dx),
      .dy        (req_dy),
      .out_valid (c_vld[0]),
      .out_hit   (c_hit[0]),
      .t_full    (c_tf[0]),
      .u_full    (c_uf[0]),
      .den       (c_den[0]),
      .num_t     (c_rt[0]),
      .num_u     (c_ru[0]),
      .a_x       (c_ax[0]),
      .a_y       (c_ay[0]),
      .r_x       (c_rx[0]),
      .r_y       (c_ry[0])
   );

   assign c_qt[0] = '0;
   assign c_qu[0] = '0;

   // Chain of division cells, one quotient bit each.
   generate
      for (genvar i = 0; i < F; i++) begin : g_cell
         sgi_div_cell #(.COORD_BITS(C), .PARAM_FRAC_BITS(F)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (c_vld[i]),
            .in_hit     (c_hit[i]),
            .in_t_full  (c_tf[i]),
            .in_u_full  (c_uf[i]),
            .in_den     (c_den[i]),
            .in_rem_t   (c_rt[i]),
            .in_rem_u   (c_ru[i]),
            .in_q_t     (c_qt[i]),
            .in_q_u     (c_qu[i]),
            .in_a_x     (c_ax[i]),
            .in_a_y     (c_ay[i]),
            .in_r_x     (c_rx[i]),
            .in_r_y     (c_ry[i]),
            .out_valid  (c_vld[i+1]),
            .out_hit    (c_hit[i+1]),
            .out_t_full (c_tf[i+1]),
            .out_u_full (c_uf[i+1]),
            .out_den    (c_den[i+1]),
            .out_rem_t  (c_rt[i+1]),
            .out_rem_u  (c_ru[i+1]),
            .out_q_t    (c_qt[i+1]),
            .out_q_u    (c_qu[i+1]),
            .out_a_x    (c_ax[i+1]),
            .out_a_y    (c_ay[i+1]),
            .out_r_x    (c_rx[i+1]),
            .out_r_y    (c_ry[i+1])
         );
      end
   endgenerate

   // Crossing point and result register.
   sgi_point #(
      .COORD_BITS      (C),
      .PARAM_FRAC_BITS (F),
      .POINT_FRAC_BITS (POINT_FRAC_BITS)
   ) u_point (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c_vld[F]),
      .in_hit      (c_hit[F]),
      .in_t_full   (c_tf[F]),
      .in_u_full   (c_uf[F]),
      .in_q_t      (c_qt[F]),
      .in_q_u      (c_qu[F]),
      .in_a_x      (c_ax[F]),
      .in_a_y      (c_ay[F]),
      .in_r_x      (c_rx[F]),
      .in_r_y      (c_ry[F]),
      .rsp_valid   (rsp_valid),
      .rsp_hit     (rsp_hit),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_t_param (rsp_t_param),
      .rsp_u_param (rsp_u_param)
   );

   // A hit is only ever reported with its strobe.
   a_hit_valid : assert property (@(posedge clock) rsp_hit |-> rsp_valid)
      else $error("hit reported without result strobe");

   // A miss carries all zero fields.
   a_miss_zero : assert property (@(posedge clock) !rsp_hit |->
         (rsp_point_x == '0) && (rsp_point_y == '0)
         && (rsp_t_param == '0) && (rsp_u_param == '0))
      else $error("miss with nonzero result fields");

   // Parameters of a hit stay within the unit interval.
   a_param_range : assert property (@(posedge clock) rsp_hit |->
         (rsp_t_param <= ONE) && (rsp_u_param <= ONE))
      else $error("parameter above one");

endmodule

// File: test/tb_segment_intersection.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection
// Self-checking bench for the segment intersection block. Segment pairs are
// driven through the start/busy command port with random gaps. An internal
// predictor computes the exact cross products, hit test, fixed-point t, u and
// crossing point. A scoreboard compares each strobed result with the oldest
// expectation, field by field.
// ----------------------------------------------------------------------------
module tb_segment_intersection;

   localparam int CB  = sgi_pkg::COORD_BITS_DEF;
   localparam int PFB = sgi_pkg::PARAM_FRAC_BITS_DEF;
   localparam int QFB = sgi_pkg::POINT_FRAC_BITS_DEF;
   localparam int PTW = CB + QFB;
   localparam int LATENCY = PFB + 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct packed {
      logic                  hit;
      logic signed [PTW-1:0] px;
      logic signed [PTW-1:0] py;
      logic [PFB:0]          tp;
      logic [PFB:0]          up;
   } crossing_type;

   // Truncated quotient num/den with PFB fraction bits, 0 <= num <= den.
   function automatic logic [PFB:0] param_quotient(longint num, longint den);
      longint rem;
      longint q;
      rem = num;
      q = 0;
      if (num >= den) return (PFB+1)'(longint'(1) <<< PFB);
      for (int i = 0; i < PFB; i++) begin
         rem = rem <<< 1;
         q = q <<< 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 1;
         end
      end
      return q[PFB:0];
   endfunction

   // Floor of (a + d*tq) at QFB fraction bits.
   function automatic logic signed [PTW-1:0] crossing_coord(longint a, longint d,
                                                           longint tq);
      longint v;
      longint m;
      v = a * (longint'(1) <<< PFB) + d * tq;
      if (QFB >= PFB) return PTW'(v <<< (QFB - PFB));
      if (v >= 0) return PTW'(v >>> (PFB - QFB));
      m = -v;
      m = (m + ((longint'(1) <<< (PFB - QFB)) - 1)) >>> (PFB - QFB);
      return PTW'(-m);
   endfunction

   function automatic crossing_type predict_crossing(coord_type ax, coord_type ay,
                                                     coord_type bx, coord_type by,
                                                     coord_type cx, coord_type cy,
                                                     coord_type dx, coord_type dy);
      longint rx, ry, sx, sy, qx, qy, den, nt, nu;
      crossing_type res;
      res = '0;
      rx = longint'(bx) - longint'(ax);
      ry = longint'(by) - longint'(ay);
      sx = longint'(dx) - longint'(cx);
      sy = longint'(dy) - longint'(cy);
      qx = longint'(cx) - longint'(ax);
      qy = longint'(cy) - longint'(ay);
      den = rx * sy - ry * sx;
      nt = qx * sy - qy * sx;
      nu = qx * ry - qy * rx;
      if (den == 0) return res;
      if (den < 0) begin
         den = -den;
         nt = -nt;
         nu = -nu;
      end
      if (nt < 0 || nt > den || nu < 0 || nu > den) return res;
      res.hit = 1'b1;
      res.tp = param_quotient(nt, den);
      res.up = param_quotient(nu, den);
      res.px = crossing_coord(ax, rx, res.tp);
      res.py = crossing_coord(ay, ry, res.tp);
      return res;
   endfunction

   // Scoreboard of pending crossings in request order.
   class crossing_board_type;
      crossing_type pending[$];
      int errors = 0;
      int hits = 0;
      int checked = 0;

      function void note_request(crossing_type c);
         pending.push_back(c);
      endfunction

      function void check_result(crossing_type got);
         crossing_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (exp.hit) hits++;
         if (got.hit !== exp.hit) begin
            $error("hit: expected %0d actual %0d", exp.hit, got.hit);
            errors++;
         end
         if (got.px !== exp.px) begin
            $error("point_x: expected %0d actual %0d", exp.px, got.px);
            errors++;
         end
         if (got.py !== exp.py) begin
            $error("point_y: expected %0d actual %0d", exp.py, got.py);
            errors++;
         end
         if (got.tp !== exp.tp) begin
            $error("t_param: expected %0d actual %0d", exp.tp, got.tp);
            errors++;
         end
         if (got.up !== exp.up) begin
            $error("u_param: expected %0d actual %0d", exp.up, got.up);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   coord_type req_ax = '0, req_ay = '0, req_bx = '0, req_by_coord = '0;
   coord_type req_cx = '0, req_cy = '0, req_dx = '0, req_dy = '0;
   logic rsp_valid, rsp_hit;
   logic signed [PTW-1:0] rsp_point_x, rsp_point_y;
   logic [PFB:0] rsp_t_param, rsp_u_param;

   crossing_board_type board = new();
   int idle_cycles = 0;
   bit quiet_phase = 1'b0;

   always #5 clock = ~clock;

   segment_intersection dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ax(req_ax), .req_ay(req_ay), .req_bx(req_bx),
      .req_by_coord(req_by_coord), .req_cx(req_cx), .req_cy(req_cy),
      .req_dx(req_dx), .req_dy(req_dy), .rsp_valid(rsp_valid),
      .rsp_hit(rsp_hit), .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_t_param(rsp_t_param), .rsp_u_param(rsp_u_param)
   );

   // Result checking and the watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            board.check_result({rsp_hit, rsp_point_x, rsp_point_y,
                                rsp_t_param, rsp_u_param});
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending",
                     board.pending.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   // Drive one segment pair and hold it until the transfer happens.
   task automatic send_pair(coord_type ax, coord_type ay, coord_type bx, coord_type by,
                            coord_type cx, coord_type cy, coord_type dx, coord_type dy);
      while (!quiet_phase && $urandom_range(99) < 29) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_ax <= ax; req_ay <= ay; req_bx <= bx; req_by_coord <= by;
      req_cx <= cx; req_cy <= cy; req_dx <= dx; req_dy <= dy;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(predict_crossing(ax, ay, bx, by, cx, cy, dx, dy));
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(5))
         0: return coord_type'(16'sh7fff - $urandom_range(3));
         1: return coord_type'(16'sh8000 + $urandom_range(3));
         2: return coord_type'($urandom_range(15) - 8);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Random pair built to cross: C and D on opposite sides around a point on AB.
   task automatic send_crossing_pair();
      coord_type ax, ay, bx, by, mx, my, ox, oy;
      ax = rand_coord(); ay = rand_coord(); bx = rand_coord(); by = rand_coord();
      mx = coord_type'((longint'(ax) + longint'(bx)) >>> 1);
      my = coord_type'((longint'(ay) + longint'(by)) >>> 1);
      ox = coord_type'($urandom_range(2000) - 1000);
      oy = coord_type'($urandom_range(2000) - 1000);
      send_pair(ax, ay, bx, by, coord_type'(mx - ox), coord_type'(my - oy),
                coord_type'(mx + ox), coord_type'(my + oy));
   endtask

   initial begin
      coord_type lo, hi;
      int wait_cycles;
      lo = 16'sh8000;
      hi = 16'sh7fff;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: plain cross, endpoint touches, parallel, collinear overlap,
      // zero-length segments, extreme corners and a near miss.
      send_pair(0, 0, 10, 10, 0, 10, 10, 0);
      send_pair(0, 0, 10, 0, 10, 0, 10, 10);
      send_pair(0, 0, 10, 0, 0, 0, 0, 10);
      send_pair(0, 0, 10, 0, 5, 0, 5, 7);
      send_pair(0, 0, 10, 0, 0, 1, 10, 1);
      send_pair(0, 0, 10, 0, 5, 0, 15, 0);
      send_pair(3, 3, 3, 3, 0, 0, 6, 6);
      send_pair(0, 0, 6, 6, 2, 2, 2, 2);
      send_pair(lo, lo, hi, hi, lo, hi, hi, lo);
      send_pair(hi, lo, lo, hi, lo, lo, hi, hi);
      send_pair(lo, lo, hi, lo, lo, lo, lo, hi);
      send_pair(hi, hi, lo, hi, hi, hi, hi, lo);
      send_pair(lo, 0, hi, 0, 0, lo, 0, hi);
      send_pair(0, 0, 10, 0, 11, -5, 11, 5);
      send_pair(-7, -3, 5, 9, 4, -8, -6, 11);
      send_pair(1, 0, 0, 3, 0, 0, 3, 1);
      send_pair(hi, hi, hi, hi, lo, lo, lo, lo);
      send_pair(-1, -1, -1, -1, -1, -1, -1, -1);

      // Random stream, with a quiet stretch and a drain pause mid-way.
      for (int n = 0; n < 1400; n++) begin
         quiet_phase = (n >= 400 && n < 600);
         if (n == 700) begin
            start <= 1'b0;
            @(posedge clock);
            while (board.pending.size() != 0) @(posedge clock);
         end
         if ($urandom_range(99) < 70) send_crossing_pair();
         else send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      start <= 1'b0;

      // Drain, then a short settle for any stray result.
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 20 * LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (board.pending.size() != 0) begin
         $error("%0d results never arrived", board.pending.size());
         board.errors++;
      end

      $display("Checked %0d segment pairs, %0d of them crossing,",
               board.checked, board.hits);
      $display("covering endpoints, parallel and degenerate cases, extremes.");
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
